@@ design/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants for the Cartesian to spherical converter: default sizes,
// fixed port widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int IN_W       = 32;
    localparam int OUT_DIST_W = 32;
    localparam int OUT_ANG_W  = 16;

    // The larger CORDIC operand is normalised so that its top bit is bit 60.
    localparam int NORM_TOP   = 60;
    localparam int NORM_STEPS = 6;
    localparam int CX_W       = 64;
    localparam int ACC_W      = 34;
    localparam int ATAN_DEPTH = 32;

    // atan(2^-i) with 2^32 units to a full turn.
    localparam logic [31:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

`default_nettype wire

@@ design/c2s_sqrt.sv @@
// ----------------------------------------------------------------------------
// c2s_sqrt
// Pipelined integer square root, one result bit per stage, rounded to nearest
// in a final stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt #(
    parameter int WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [2*WIDTH-1:0]   i_radicand,
    output logic      [WIDTH-1:0]     o_root
);
    import c2s_pkg::*;

    localparam int RAD_W = 2 * WIDTH;
    localparam int REM_W = WIDTH + 1;
    localparam int SUB_W = WIDTH + 3;

    logic [REM_W-1:0] w_rem  [0:WIDTH-1];
    logic [WIDTH-1:0] w_root [0:WIDTH-1];
    logic [RAD_W-1:0] w_rad  [0:WIDTH-1];

    logic [REM_W-1:0] r_rem  [1:WIDTH];
    logic [WIDTH-1:0] r_root [1:WIDTH];
    logic [RAD_W-1:0] r_rad  [1:WIDTH-1];
    logic [WIDTH-1:0] r_out;

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_radicand;

    for (genvar k = 1; k < WIDTH; k++) begin : g_link
        assign w_rem[k]  = r_rem[k];
        assign w_root[k] = r_root[k];
        assign w_rad[k]  = r_rad[k];
    end

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        logic [SUB_W-1:0] n_shift;
        logic [SUB_W-1:0] n_trial;
        logic [SUB_W-1:0] n_diff;

        assign n_shift = {w_rem[k], w_rad[k][RAD_W-1 -: 2]};
        assign n_trial = SUB_W'({w_root[k], 2'b01});
        assign n_diff  = n_shift - n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_shift >= n_trial) begin
                    r_rem[k+1]  <= n_diff[REM_W-1:0];
                    r_root[k+1] <= {w_root[k][WIDTH-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= n_shift[REM_W-1:0];
                    r_root[k+1] <= {w_root[k][WIDTH-2:0], 1'b0};
                end
            end
        end

        if (k < WIDTH - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k+1] <= {w_rad[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    // A remainder above the root means the true root lies past the midpoint.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_rem[WIDTH] > REM_W'(r_root[WIDTH])) begin
                r_out <= r_root[WIDTH] + WIDTH'(1);
            end else begin
                r_out <= r_root[WIDTH];
            end
        end
    end

    assign o_root = r_out;

endmodule

`default_nettype wire

@@ design/c2s_atan.sv @@
// ----------------------------------------------------------------------------
// c2s_atan
// First-quadrant atan2(b, a) for nonnegative operands: octant fold, staged
// normalisation, pipelined vectoring CORDIC, then rounding and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_atan #(
    parameter int COORD_W = 32,
    parameter int ANGLE_W = 16,
    parameter int STAGES  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [COORD_W-1:0]   i_a,
    input  wire logic [COORD_W-1:0]   i_b,
    output logic      [ANGLE_W-1:0]   o_angle
);
    import c2s_pkg::*;

    localparam int NORM_W = NORM_TOP + 1;
    localparam int SH     = 32 - ANGLE_W;
    localparam int NFLG   = NORM_STEPS + STAGES;
    localparam logic signed [ACC_W-1:0] EIGHTH  = ACC_W'(1 << (ANGLE_W - 3));
    localparam logic        [ANGLE_W-1:0] QUARTER = ANGLE_W'(1 << (ANGLE_W - 2));

    // Flag bit 1: operands were swapped. Flag bit 0: both operands are zero.
    logic [1:0]        r_flg   [0:NFLG];
    logic [NORM_W-1:0] r_big   [0:NORM_STEPS];
    logic [NORM_W-1:0] r_small [0:NORM_STEPS];

    logic signed [CX_W-1:0]  w_cx  [0:STAGES-1];
    logic signed [CX_W-1:0]  w_cy  [0:STAGES-1];
    logic signed [ACC_W-1:0] w_acc [0:STAGES-1];
    logic signed [CX_W-1:0]  r_cx  [1:STAGES-1];
    logic signed [CX_W-1:0]  r_cy  [1:STAGES-1];
    logic signed [ACC_W-1:0] r_acc [1:STAGES];
    logic [ANGLE_W-1:0]      r_out;

    logic n_swp;
    assign n_swp = i_b > i_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flg[0]   <= {n_swp, (i_a == '0) && (i_b == '0)};
            r_big[0]   <= NORM_W'(n_swp ? i_b : i_a);
            r_small[0] <= NORM_W'(n_swp ? i_a : i_b);
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int S = 32 >> j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flg[j+1] <= r_flg[j];
                if (r_big[j][NORM_TOP -: S] == '0) begin
                    r_big[j+1]   <= r_big[j] << S;
                    r_small[j+1] <= r_small[j] << S;
                end else begin
                    r_big[j+1]   <= r_big[j];
                    r_small[j+1] <= r_small[j];
                end
            end
        end
    end

    assign w_cx[0]  = $signed(CX_W'(r_big[NORM_STEPS]));
    assign w_cy[0]  = $signed(CX_W'(r_small[NORM_STEPS]));
    assign w_acc[0] = '0;

    for (genvar i = 1; i < STAGES; i++) begin : g_link
        assign w_cx[i]  = r_cx[i];
        assign w_cy[i]  = r_cy[i];
        assign w_acc[i] = r_acc[i];
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_cordic
        localparam logic signed [ACC_W-1:0] STEP = $signed(ACC_W'(ATAN_TAB[i]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flg[NORM_STEPS+1+i] <= r_flg[NORM_STEPS+i];
                if (!w_cy[i][CX_W-1]) begin
                    r_acc[i+1] <= w_acc[i] + STEP;
                end else begin
                    r_acc[i+1] <= w_acc[i] - STEP;
                end
            end
        end

        if (i < STAGES - 1) begin : g_xy
            logic signed [CX_W-1:0] n_dx;
            logic signed [CX_W-1:0] n_dy;
            assign n_dx = w_cy[i] >>> i;
            assign n_dy = w_cx[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!w_cy[i][CX_W-1]) begin
                        r_cx[i+1] <= w_cx[i] + n_dx;
                        r_cy[i+1] <= w_cy[i] - n_dy;
                    end else begin
                        r_cx[i+1] <= w_cx[i] - n_dx;
                        r_cy[i+1] <= w_cy[i] + n_dy;
                    end
                end
            end
        end
    end

    logic signed [ACC_W-1:0] n_q;
    if (SH > 0) begin : g_round
        assign n_q = (r_acc[STAGES] + $signed(ACC_W'(1 << (SH - 1)))) >>> SH;
    end else begin : g_exact
        assign n_q = r_acc[STAGES];
    end

    logic [ANGLE_W-1:0] n_oct;
    logic [ANGLE_W-1:0] n_angle;
    always_comb begin
        if (n_q[ACC_W-1]) begin
            n_oct = '0;
        end else if (n_q > EIGHTH) begin
            n_oct = EIGHTH[ANGLE_W-1:0];
        end else begin
            n_oct = n_q[ANGLE_W-1:0];
        end
        if (r_flg[NFLG][0]) begin
            n_angle = '0;
        end else if (r_flg[NFLG][1]) begin
            n_angle = QUARTER - n_oct;
        end else begin
            n_angle = n_oct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_angle;
        end
    end

    assign o_angle = r_out;

endmodule

`default_nettype wire

@@ design/cartesian_to_spherical.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts a point (x, y, z) in whole metres into range, cylindrical radius,
// polar angle and azimuth, with binary angles of ANGLE_WIDTH bits.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid, o_in_ready) carries one point per beat in
// i_pos_x, i_pos_y and i_pos_z; the output channel (o_out_valid, i_out_ready)
// carries the matching result beat. Every point gives exactly one result,
// in order.
// Throughput is one beat per cycle while the receiver takes results. A beat
// passes through magnitude and squaring, the bit-per-stage square root, the
// arctangent pipeline (fold, six normalisation steps, the CORDIC stages and
// rounding), and the output register; with the default sizes the square
// root is the longest part.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready falls; nothing is dropped or repeated, and a new beat is
// taken in the same cycle that the waiting result leaves.
// A synchronous active-low reset clears the valid bits only; the pipeline
// comes up empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = c2s_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [c2s_pkg::IN_W-1:0]    i_pos_x,
    input  wire logic signed [c2s_pkg::IN_W-1:0]    i_pos_y,
    input  wire logic signed [c2s_pkg::IN_W-1:0]    i_pos_z,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [c2s_pkg::OUT_DIST_W-1:0]          o_range_m,
    output logic [c2s_pkg::OUT_DIST_W-1:0]          o_radial_xy_m,
    output logic [c2s_pkg::OUT_ANG_W-1:0]           o_polar_angle,
    output logic [c2s_pkg::OUT_ANG_W-1:0]           o_azimuth_angle
);
    import c2s_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int A      = ANGLE_WIDTH;
    localparam int NS     = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
    localparam int SQ_W   = 2 * W;
    localparam int H      = (W + 1) / 2;
    localparam int SQ_LAT = W + 1;
    localparam int AT_LAT = NS + NORM_STEPS + 2;
    localparam int D1     = 4 + SQ_LAT;
    localparam int LAT    = 5 + SQ_LAT + AT_LAT + 1;
    localparam int SIDE_W = 3 * W + 3;
    localparam int TAIL_W = 3 + 2 * W;
    localparam logic [A-1:0] HALF = A'(1 << (A - 1));

    // One enable for every stage: the pipeline moves unless a result waits and the receiver is not ready.
    logic w_en;
    logic r_vld [0:LAT-1];

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: magnitudes and signs of the low COORD_WIDTH bits.
    logic [W-1:0] w_raw [0:2];
    logic [W-1:0] r1_mag [0:2];
    logic         r1_neg [0:2];

    if (W <= IN_W) begin : g_narrow
        assign w_raw[0] = i_pos_x[W-1:0];
        assign w_raw[1] = i_pos_y[W-1:0];
        assign w_raw[2] = i_pos_z[W-1:0];
    end else begin : g_wide
        assign w_raw[0] = W'(unsigned'(i_pos_x));
        assign w_raw[1] = W'(unsigned'(i_pos_y));
        assign w_raw[2] = W'(unsigned'(i_pos_z));
    end

    // Stages 2 and 3: each square is built from half-width partial products.
    logic [2*H-1:0]     r2_ll [0:2];
    logic [W-1:0]       r2_lh [0:2];
    logic [2*(W-H)-1:0] r2_hh [0:2];
    logic [SQ_W-1:0]    r3_sq [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [H-1:0]   n_lo;
        logic [W-H-1:0] n_hi;
        assign n_lo = r1_mag[c][H-1:0];
        assign n_hi = r1_mag[c][W-1:H];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_neg[c] <= w_raw[c][W-1];
                r1_mag[c] <= w_raw[c][W-1] ? (W'(0) - w_raw[c]) : w_raw[c];
                r2_ll[c]  <= (2*H)'(n_lo) * (2*H)'(n_lo);
                r2_lh[c]  <= W'(n_lo) * W'(n_hi);
                r2_hh[c]  <= (2*(W-H))'(n_hi) * (2*(W-H))'(n_hi);
                r3_sq[c]  <= (SQ_W'(r2_hh[c]) << (2 * H))
                           + (SQ_W'(r2_lh[c]) << (H + 1))
                           + SQ_W'(r2_ll[c]);
            end
        end
    end

    // Stages 4 and 5: x^2 + y^2, then the full sum of squares.
    logic [SQ_W-1:0] r4_sxy;
    logic [SQ_W-1:0] r4_sz;
    logic [SQ_W-1:0] r5_sxy;
    logic [SQ_W-1:0] r5_tot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sxy <= r3_sq[0] + r3_sq[1];
            r4_sz  <= r3_sq[2];
            r5_sxy <= r4_sxy;
            r5_tot <= r4_sxy + r4_sz;
        end
    end

    logic [W-1:0] w_range;
    logic [W-1:0] w_rho;

    c2s_sqrt #(.WIDTH(W)) u_sqrt_range (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (r5_tot),
        .o_root     (w_range)
    );

    c2s_sqrt #(.WIDTH(W)) u_sqrt_rho (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (r5_sxy),
        .o_root     (w_rho)
    );

    // Signs and magnitudes wait alongside the square roots.
    logic [SIDE_W-1:0] r_side [0:D1-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= {r1_neg[0], r1_neg[1], r1_neg[2],
                          r1_mag[0], r1_mag[1], r1_mag[2]};
            for (int k = 1; k < D1; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic         w_nx, w_ny, w_nz;
    logic [W-1:0] w_ax, w_ay, w_az;
    assign {w_nx, w_ny, w_nz, w_ax, w_ay, w_az} = r_side[D1-1];

    logic [A-1:0] w_theta_q;
    logic [A-1:0] w_phi_q;

    // Polar angle uses the rounded cylindrical radius against |z|.
    c2s_atan #(.COORD_W(W), .ANGLE_W(A), .STAGES(NS)) u_atan_polar (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (w_az),
        .i_b     (w_rho),
        .o_angle (w_theta_q)
    );

    c2s_atan #(.COORD_W(W), .ANGLE_W(A), .STAGES(NS)) u_atan_azimuth (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (w_ax),
        .i_b     (w_ay),
        .o_angle (w_phi_q)
    );

    // Signs and distances wait alongside the arctangent pipelines.
    logic [TAIL_W-1:0] r_tail [0:AT_LAT-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tail[0] <= {w_nx, w_ny, w_nz, w_range, w_rho};
            for (int k = 1; k < AT_LAT; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    logic         w_tnx, w_tny, w_tnz;
    logic [W-1:0] w_trange, w_trho;
    assign {w_tnx, w_tny, w_tnz, w_trange, w_trho} = r_tail[AT_LAT-1];

    // Quadrant mapping; the azimuth wraps naturally in A bits.
    logic [A-1:0] n_theta;
    logic [A-1:0] n_phi;
    always_comb begin
        n_theta = w_tnz ? (HALF - w_theta_q) : w_theta_q;
        if (w_tnx) begin
            n_phi = w_tny ? (HALF + w_phi_q) : (HALF - w_phi_q);
        end else begin
            n_phi = w_tny ? (A'(0) - w_phi_q) : w_phi_q;
        end
    end

    // Distances saturate only when coordinates are wider than 32 bits.
    logic [OUT_DIST_W-1:0] n_range;
    logic [OUT_DIST_W-1:0] n_rho;
    if (W > OUT_DIST_W) begin : g_sat
        assign n_range = (|w_trange[W-1:OUT_DIST_W]) ? '1 : w_trange[OUT_DIST_W-1:0];
        assign n_rho   = (|w_trho[W-1:OUT_DIST_W])   ? '1 : w_trho[OUT_DIST_W-1:0];
    end else begin : g_fit
        assign n_range = OUT_DIST_W'(w_trange);
        assign n_rho   = OUT_DIST_W'(w_trho);
    end

    logic [OUT_ANG_W-1:0] n_polar;
    logic [OUT_ANG_W-1:0] n_azim;
    if (A >= OUT_ANG_W) begin : g_ang_cut
        assign n_polar = n_theta[OUT_ANG_W-1:0];
        assign n_azim  = n_phi[OUT_ANG_W-1:0];
    end else begin : g_ang_ext
        assign n_polar = OUT_ANG_W'(n_theta);
        assign n_azim  = OUT_ANG_W'(n_phi);
    end

    logic [OUT_DIST_W-1:0] r_range;
    logic [OUT_DIST_W-1:0] r_rho;
    logic [OUT_ANG_W-1:0]  r_polar;
    logic [OUT_ANG_W-1:0]  r_azim;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_range <= n_range;
            r_rho   <= n_rho;
            r_polar <= n_polar;
            r_azim  <= n_azim;
        end
    end

    assign o_range_m       = r_range;
    assign o_radial_xy_m   = r_rho;
    assign o_polar_angle   = r_polar;
    assign o_azimuth_angle = r_azim;

endmodule

`default_nettype wire

@@ bench/cartesian_to_spherical_tb.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb
// Self-checking bench for the Cartesian to spherical converter. A driver
// sends points from a queue in random bursts; a monitor checks each result
// beat against a bit-exact model of the fixed-point square roots and CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2s_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int NS = CORDIC_STAGES_DEF;
    localparam int N_RANDOM = 1750;
    localparam int LATENCY = CW + NS + 15;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    typedef struct packed {
        logic [31:0] rng;
        logic [31:0] rho;
        logic [15:0] polar;
        logic [15:0] azim;
    } t_sph;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_range_m;
    logic [31:0] o_radial_xy_m;
    logic [15:0] o_polar_angle;
    logic [15:0] o_azimuth_angle;

    cartesian_to_spherical u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_range_m      (o_range_m),
        .o_radial_xy_m  (o_radial_xy_m),
        .o_polar_angle  (o_polar_angle),
        .o_azimuth_angle(o_azimuth_angle)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_point pending_points[$];
    t_sph   expected_coords[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     hold_off = 1'b0;

    // Rounded integer square root of a sum of squares, which stays below 2^64; ties cannot occur.
    function automatic logic [63:0] nearest_sqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] rem;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        rem = s - {64'd0, r} * {64'd0, r};
        if (rem > {64'd0, r}) r = r + 1;
        return r;
    endfunction

    // atan(small/big) for small <= big, in binary-angle units, clamped to an
    // eighth of a turn. The operands are normalised so big has bit 60 set.
    function automatic logic [63:0] cordic_octant(input logic [63:0] big,
                                                  input logic [63:0] sml);
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] acc;
        logic signed [63:0] q;
        int sh;
        if (big == 0) return 0;
        while (big < (64'd1 << 60)) begin
            big = big << 1;
            sml = sml << 1;
        end
        cx = big;
        cy = sml;
        acc = 0;
        for (int i = 0; i < (NS > 32 ? 32 : NS); i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx; cy = cy - dy; acc = acc + $signed({32'd0, ATAN_TAB[i]});
            end else begin
                cx = cx - dx; cy = cy + dy; acc = acc - $signed({32'd0, ATAN_TAB[i]});
            end
        end
        sh = 32 - AW;
        q = (sh > 0) ? ((acc + (64'sd1 <<< (sh - 1))) >>> sh) : acc;
        if (q < 0) q = 0;
        if (q > (64'sd1 <<< (AW - 3))) q = 64'sd1 <<< (AW - 3);
        return q;
    endfunction

    function automatic logic [63:0] quadrant_atan(input logic [63:0] a,
                                                  input logic [63:0] b);
        if (b > a) return (64'd1 << (AW - 2)) - cordic_octant(b, a);
        return cordic_octant(a, b);
    endfunction

    function automatic t_sph spherical_of(input t_point p);
        logic [63:0]  ax, ay, az, rr, rho, theta, phi, a;
        logic [127:0] sxy;
        logic         nx, ny, nz;
        logic [63:0]  full;
        logic [63:0]  half;
        t_sph         res;
        full = 64'd1 << AW;
        half = full >> 1;
        nx = p.x[CW-1];
        ny = p.y[CW-1];
        nz = p.z[CW-1];
        ax = nx ? (64'd1 << CW) - {32'd0, p.x} : {32'd0, p.x};
        ay = ny ? (64'd1 << CW) - {32'd0, p.y} : {32'd0, p.y};
        az = nz ? (64'd1 << CW) - {32'd0, p.z} : {32'd0, p.z};
        sxy = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        rr  = nearest_sqrt(sxy + {64'd0, az} * {64'd0, az});
        rho = nearest_sqrt(sxy);
        theta = quadrant_atan(az, rho);
        if (nz) theta = half - theta;
        a = quadrant_atan(ax, ay);
        if (nx) phi = ny ? half + a : half - a;
        else    phi = ny ? full - a : a;
        phi = phi & (full - 1);
        res.rng   = (rr  > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rr[31:0];
        res.rho   = (rho > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rho[31:0];
        res.polar = theta[15:0];
        res.azim  = phi[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] rand_coord();
        // Full-range words as the largest share, with small values and the extremes mixed in
        // so that the axes, octant boundaries and sign corners are all reached.
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(0, 40) - 20;
            4:       return 32'd0;
            5:       return $signed($urandom_range(0, 65535)) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        pending_points.push_back('{x: x, y: y, z: z});
    endtask

    // The handshake as seen at the last rising edge; the driver uses it at
    // the following falling edge to decide whether the beat was taken.
    logic o_in_ready_q = 1'b0;

    // Driver: the point on the pins is the head of the queue, and it is only
    // removed once its beat has been taken, so valid never drops early.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) void'(pending_points.pop_front());
            if (gap_left > 0 && !(i_in_valid && !o_in_ready_q)) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                if (!(i_in_valid && !o_in_ready_q)) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    burst_left--;
                end
                i_in_valid <= 1'b1;
                i_pos_x <= pending_points[0].x;
                i_pos_y <= pending_points[0].y;
                i_pos_z <= pending_points[0].z;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        o_in_ready_q <= o_in_ready;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_coords.push_back(spherical_of('{x: i_pos_x, y: i_pos_y, z: i_pos_z}));
    end

    // Receiver: its own stall pattern, plus one long hold-off that lets the
    // pipeline fill and push back on the sender.
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % 23;
        if (hold_off)
            i_out_ready <= 1'b0;
        else if (stall_phase < 6)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        wait (cycle_count == 700);
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor: each result beat is compared with the oldest expectation.
    t_sph want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_coords.size() == 0) begin
                report_mismatch("unexpected beat", o_range_m, 0);
            end else begin
                want = expected_coords.pop_front();
                if (o_range_m !== want.rng) report_mismatch("range", o_range_m, want.rng);
                if (o_radial_xy_m !== want.rho)
                    report_mismatch("radial", o_radial_xy_m, want.rho);
                if (o_polar_angle !== want.polar)
                    report_mismatch("polar", o_polar_angle, want.polar);
                if (o_azimuth_angle !== want.azim)
                    report_mismatch("azimuth", o_azimuth_angle, want.azim);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        // Directed points: origin, each axis both ways, the signed extremes,
        // the negative x axis, octant diagonals and points in the xy plane.
        push_point(0, 0, 0);
        push_point(0, 0, 5);
        push_point(0, 0, -5);
        push_point(0, 0, 32'h8000_0000);
        push_point(-7, 0, 0);
        push_point(7, 0, 0);
        push_point(0, 7, 0);
        push_point(0, -7, 0);
        push_point(32'h8000_0000, 0, 0);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_point(3, 3, 0);
        push_point(-3, 3, 0);
        push_point(-3, -3, 1);
        push_point(3, -3, -1);
        push_point(3, 4, 12);
        push_point(-1, -1, -1);
        push_point(1, 2, 0);
        push_point(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        for (int n = 0; n < N_RANDOM; n++)
            push_point(rand_coord(), rand_coord(), rand_coord());
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_points.size() == 0);
        @(posedge i_clk);
        wait (expected_coords.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_coords.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
